[hw/rtl/csx_pkg.sv]
// Shared types, constants and helpers for the CAN signal extractor.
// No dependencies; imported by every module of the block.
package csx_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int WORD_W = 64;
  localparam int FRAME_BITS = (FRAME_BYTES * 8 > WORD_W) ? WORD_W : FRAME_BYTES * 8;

  localparam int START_W = 6;
  localparam int LEN_W = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_BIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED = 3'd3;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd64;

  typedef struct packed {
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   bit_length;
    logic               byte_order;
    logic               is_signed;
  } csx_cfg_t;

  // Lengths above a full word behave as a full word.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    sat_len = (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // Mask with the low len bits set; len is already saturated.
  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    if (len[LEN_W-1]) begin
      low_mask = '1;
    end else begin
      low_mask = ~({WORD_W{1'b1}} << len[LEN_W-2:0]);
    end
  endfunction

endpackage

[hw/rtl/csx_window.sv]
// Selects the source bit order and cuts the signal window out of the payload.
// Depends on csx_pkg.
module csx_window import csx_pkg::*; (
  input  logic [WORD_W-1:0] payload_i,
  input  csx_cfg_t          cfg_i,
  output logic [WORD_W-1:0] window_o,
  output logic              out_of_frame_o
);

  logic [WORD_W-1:0]  mot_bits;
  logic [WORD_W-1:0]  src_bits;
  logic [START_W-1:0] lin_start;
  logic [LEN_W-1:0]   len;
  logic [LEN_W:0]     end_pos;

  // In big-endian order each byte is read from its top bit down, which makes
  // the walk a straight upward run over the bytes with their bits reversed.
  always_comb begin
    for (int m = 0; m < WORD_W; m++) begin
      mot_bits[m] = payload_i[8 * (m / 8) + 7 - (m % 8)];
    end
  end

  always_comb begin
    len = sat_len(cfg_i.bit_length);
    if (cfg_i.byte_order) begin
      src_bits = mot_bits & low_mask(LEN_W'(FRAME_BITS));
      lin_start = {cfg_i.start_bit[START_W-1:3], ~cfg_i.start_bit[2:0]};
    end else begin
      src_bits = payload_i & low_mask(LEN_W'(FRAME_BITS));
      lin_start = cfg_i.start_bit;
    end
    window_o = (src_bits >> lin_start) & low_mask(len);
    end_pos = {2'b00, lin_start} + {1'b0, len};
    out_of_frame_o = (len != '0) && (end_pos > (LEN_W + 1)'(FRAME_BITS));
  end

endmodule

[hw/rtl/csx_format.sv]
// Puts the window bits in result order and applies sign extension.
// Depends on csx_pkg.
module csx_format import csx_pkg::*; (
  input  logic [WORD_W-1:0] window_i,
  input  csx_cfg_t          cfg_i,
  output logic [WORD_W-1:0] value_o
);

  logic [WORD_W-1:0] rev_bits;
  logic [WORD_W-1:0] raw;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  rshift;
  logic              sign;

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      rev_bits[WORD_W-1-k] = window_i[k];
    end
  end

  always_comb begin
    len = sat_len(cfg_i.bit_length);
    rshift = LEN_MAX - len;
    if (cfg_i.byte_order) begin
      raw = rev_bits >> rshift;
    end else begin
      raw = window_i;
    end
    sign = (len != '0) && raw[START_W'(len[START_W-1:0] - 1'b1)];
    if (cfg_i.is_signed && sign && !len[LEN_W-1]) begin
      value_o = raw | ~low_mask(len);
    end else begin
      value_o = raw;
    end
  end

endmodule

[hw/rtl/can_signal_extractor.sv]
// CAN signal extractor: one signal per 8-byte payload, bit field selected by registers.
// The payload and then the formatted value are registered; the result strobe comes with the value register.
// Throughput: one payload per clock; busy stays low, stages never stall.
// Reset clears the stage valid flags and loads the register defaults
// (start bit 0, length 8, Intel order, unsigned). Depends on csx_pkg.
module can_signal_extractor import csx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_W-1:0]     payload_i,
  output logic                  valid_o,
  output logic [WORD_W-1:0]     value_o,
  output logic                  out_of_frame_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  csx_cfg_t          cfg_q;
  logic              in_vld_q;
  logic [WORD_W-1:0] payload_q;
  logic              out_vld_q;
  logic [WORD_W-1:0] value_q;
  logic              oof_q;
  logic [WORD_W-1:0] window;
  logic              oof_d;
  logic [WORD_W-1:0] value_d;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_bit <= '0;
      cfg_q.bit_length <= LEN_RESET;
      cfg_q.byte_order <= 1'b0;
      cfg_q.is_signed <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_START_BIT:  cfg_q.start_bit <= cfg_data_i[START_W-1:0];
        REG_BIT_LENGTH: cfg_q.bit_length <= cfg_data_i[LEN_W-1:0];
        REG_BYTE_ORDER: cfg_q.byte_order <= cfg_data_i[0];
        REG_IS_SIGNED:  cfg_q.is_signed <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  csx_window u_window (
    .payload_i      (payload_q),
    .cfg_i          (cfg_q),
    .window_o       (window),
    .out_of_frame_o (oof_d)
  );

  csx_format u_format (
    .window_i (window),
    .cfg_i    (cfg_q),
    .value_o  (value_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      payload_q <= payload_i;
    end
    if (in_vld_q) begin
      value_q <= value_d;
      oof_q <= oof_d;
    end
  end

  assign valid_o = out_vld_q;
  assign value_o = value_q;
  assign out_of_frame_o = oof_q;

endmodule

[test/tb.sv]
// Self-checking testbench for can_signal_extractor: directed and random payloads
// under many register settings, checked against a local signal unpacker.
// Depends on csx_pkg and can_signal_extractor.
module tb;
  import csx_pkg::*;

  localparam logic ORDER_INTEL = 1'b0;
  localparam logic ORDER_MOTOROLA = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_FRAMES = 850;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [WORD_W-1:0] value;
    logic              out_of_frame;
  } signal_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [WORD_W-1:0]     payload_i = '0;
  logic                  valid_o;
  logic [WORD_W-1:0]     value_o;
  logic                  out_of_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [START_W-1:0] cfg_start;
  logic [LEN_W-1:0]   cfg_len;
  logic               cfg_order;
  logic               cfg_signed;

  signal_t pending_signals[$];
  int errors = 0;
  int frames_sent = 0;
  int signals_checked = 0;
  int config_phases = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  can_signal_extractor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .payload_i      (payload_i),
    .valid_o        (valid_o),
    .value_o        (value_o),
    .out_of_frame_o (out_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic signal_t unpack_signal(input logic [WORD_W-1:0] payload);
    signal_t res;
    int unsigned len;
    int unsigned pos;
    int unsigned dst;
    res.value = '0;
    res.out_of_frame = 1'b0;
    len = (cfg_len > 64) ? 64 : cfg_len;
    pos = cfg_start;
    for (int unsigned k = 0; k < len; k++) begin
      dst = (cfg_order == ORDER_MOTOROLA) ? len - 1 - k : k;
      if (pos >= FRAME_BITS) begin
        res.out_of_frame = 1'b1;
      end else begin
        res.value[dst] = payload[pos];
      end
      if (cfg_order == ORDER_MOTOROLA) begin
        if (pos % 8 == 0) begin
          pos += 15;
        end else begin
          pos -= 1;
        end
      end else begin
        pos += 1;
      end
    end
    if (cfg_signed && len >= 1 && len < 64 && res.value[len-1]) begin
      res.value |= {WORD_W{1'b1}} << len;
    end
    return res;
  endfunction

  task automatic send_frame(input logic [WORD_W-1:0] payload);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    start <= 1'b1;
    payload_i <= payload;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_signals.push_back(unpack_signal(payload));
    frames_sent++;
    burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_signals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_START_BIT:  cfg_start = data[START_W-1:0];
      REG_BIT_LENGTH: cfg_len = data[LEN_W-1:0];
      REG_BYTE_ORDER: cfg_order = data[0];
      REG_IS_SIGNED:  cfg_signed = data[0];
      default: ;
    endcase
  endtask

  // Unused data bits are filled at random; the block must ignore them.
  task automatic set_config(input logic [START_W-1:0] sb, input logic [LEN_W-1:0] len,
                            input logic order, input logic sgn);
    cfg_write(REG_START_BIT, {2'($urandom), sb});
    cfg_write(REG_BIT_LENGTH, {1'($urandom), len});
    cfg_write(REG_BYTE_ORDER, {7'($urandom), order});
    cfg_write(REG_IS_SIGNED, {7'($urandom), sgn});
    cfg_valid_i <= 1'b0;
    config_phases++;
  endtask

  task automatic phase(input logic [START_W-1:0] sb, input logic [LEN_W-1:0] len,
                       input logic order, input logic sgn, input logic [WORD_W-1:0] p0,
                       input logic [WORD_W-1:0] p1);
    set_config(sb, len, order, sgn);
    send_frame(p0);
    send_frame(p1);
    drain();
  endtask

  task automatic test_reset_defaults();
    send_frame('0);
    send_frame('1);
    send_frame(64'h0123_4567_89ab_cdef);
    drain();
  endtask

  task automatic test_intel();
    phase(6'd0, 7'd64, ORDER_INTEL, 1'b1, '1, 64'h8000_0000_0000_0001);
    phase(6'd63, 7'd1, ORDER_INTEL, 1'b1, '1, 64'h7fff_ffff_ffff_ffff);
    phase(6'd60, 7'd8, ORDER_INTEL, 1'b0, '1, 64'hf000_0000_0000_0000);
    phase(6'd12, 7'd0, ORDER_INTEL, 1'b1, '1, 64'h5555_aaaa_5555_aaaa);
    phase(6'd4, 7'd127, ORDER_INTEL, 1'b1, '1, 64'hfedc_ba98_7654_3210);
  endtask

  task automatic test_motorola();
    phase(6'd7, 7'd64, ORDER_MOTOROLA, 1'b0, 64'h0123_4567_89ab_cdef, '1);
    phase(6'd0, 7'd64, ORDER_MOTOROLA, 1'b1, '1, 64'h0000_0000_0000_0001);
    phase(6'd15, 7'd12, ORDER_MOTOROLA, 1'b1, 64'h0000_0000_0000_8000, 64'h0000_0000_0000_7fff);
    phase(6'd56, 7'd16, ORDER_MOTOROLA, 1'b1, '1, 64'h0100_0000_0000_0000);
  endtask

  task automatic test_unused_register();
    cfg_write(REG_UNUSED, 8'hff);
    cfg_valid_i <= 1'b0;
    send_frame(64'h8421_8421_8421_8421);
    send_frame('1);
    drain();
  endtask

  task automatic test_random();
    int left;
    int n;
    logic [START_W-1:0] sb;
    logic [LEN_W-1:0] len;
    logic [WORD_W-1:0] payload;
    left = RANDOM_FRAMES;
    while (left > 0) begin
      sb = START_W'($urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0) sb = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      case ($urandom_range(0, 9))
        0: len = 7'd0;
        1: len = LEN_W'($urandom_range(65, 127));
        2: len = 7'd64;
        3: len = 7'd1;
        default: len = LEN_W'($urandom_range(1, 64));
      endcase
      set_config(sb, len, 1'($urandom), 1'($urandom));
      n = $urandom_range(10, 60);
      if (n > left) n = left;
      repeat (n) begin
        case ($urandom_range(0, 15))
          0: payload = '0;
          1: payload = '1;
          default: payload = {$urandom, $urandom};
        endcase
        send_frame(payload);
      end
      left -= n;
      drain();
    end
  endtask

  always @(posedge clk_i) begin
    signal_t exp;
    if (rst_ni && valid_o) begin
      if (pending_signals.size() == 0) begin
        $error("unexpected result: value %h out_of_frame %b", value_o, out_of_frame_o);
        errors++;
      end else begin
        exp = pending_signals.pop_front();
        if (value_o !== exp.value) begin
          $error("value: expected %h, got %h", exp.value, value_o);
          errors++;
        end
        if (out_of_frame_o !== exp.out_of_frame) begin
          $error("out_of_frame: expected %b, got %b", exp.out_of_frame, out_of_frame_o);
          errors++;
        end
        signals_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb: watchdog expired with %0d results outstanding", pending_signals.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_start = START_W'(0);
    cfg_len = LEN_RESET;
    cfg_order = ORDER_INTEL;
    cfg_signed = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_intel();
    test_motorola();
    test_unused_register();
    test_random();
    if (pending_signals.size() != 0) begin
      $error("%0d expected results never arrived", pending_signals.size());
      errors++;
    end
    $display("tb: %0d frames sent, %0d signals checked over %0d register settings",
             frames_sent, signals_checked, config_phases);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
